// File: rtl/core/csmab_pkg.sv
// Shared types, register indexes and reset values for the CSMA/CA backoff station.
// Used by the configuration, core and top-level modules; depends on nothing.
`default_nettype none

package csmab_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 16;

   localparam logic [CsrIndexWidth-1:0] CSR_DIFS_SLOTS    = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_CW_MIN        = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_CW_MAX        = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_INITIAL_BE    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_BE        = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_PAYLOAD_SLOTS = 3'd5;

   localparam logic [7:0]  RESET_DIFS_SLOTS    = 8'd2;
   localparam logic [15:0] RESET_CW_MIN        = 16'd0;
   localparam logic [15:0] RESET_CW_MAX        = 16'd1024;
   localparam logic [3:0]  RESET_INITIAL_BE    = 4'd3;
   localparam logic [3:0]  RESET_MAX_BE        = 4'd10;
   localparam logic [15:0] RESET_PAYLOAD_SLOTS = 16'd1;

   localparam logic [1:0] CH_IDLE  = 2'd0;
   localparam logic [1:0] CH_DIRTY = 2'd2;

   localparam logic [2:0] STATION_WAIT     = 3'd0;
   localparam logic [2:0] STATION_TRANSMIT = 3'd1;
   localparam logic [2:0] STATION_BACKOFF  = 3'd2;
   localparam logic [2:0] STATION_COMPLETE = 3'd3;
   localparam logic [2:0] STATION_EXITED   = 3'd4;

   typedef enum logic [4:0] {
      PH_WAIT     = 5'b00001,
      PH_TX       = 5'b00010,
      PH_BACKOFF  = 5'b00100,
      PH_COMPLETE = 5'b01000,
      PH_EXITED   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0]  difs_slots;
      logic [15:0] cw_min;
      logic [15:0] cw_max;
      logic [3:0]  initial_be;
      logic [3:0]  max_be;
      logic [15:0] payload_slots;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  station_state;
      logic        transmitting;
      logic [15:0] backoff_left;
      logic [3:0]  backoff_exponent;
      logic [15:0] retry_count;
      logic [31:0] finish_slot;
   } rsp_type;

   function automatic logic [2:0] station_code(input phase_type phase);
      logic [2:0] code;
      case (phase)
         PH_WAIT:     code = STATION_WAIT;
         PH_TX:       code = STATION_TRANSMIT;
         PH_BACKOFF:  code = STATION_BACKOFF;
         PH_COMPLETE: code = STATION_COMPLETE;
         PH_EXITED:   code = STATION_EXITED;
         default:     code = STATION_WAIT;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/csmab_cfg.sv
// Configuration register file of the backoff station, written through a plain write port.
// Depends on csmab_pkg for register indexes, reset values and the configuration struct.
`default_nettype none

module csmab_cfg (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write_en,
   input  wire logic [csmab_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [csmab_pkg::CsrDataWidth-1:0]     csr_wdata,
   output csmab_pkg::cfg_type                          cfg
);

   csmab_pkg::cfg_type cfg_ff;
   csmab_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            csmab_pkg::CSR_DIFS_SLOTS:    cfg_in.difs_slots    = csr_wdata[7:0];
            csmab_pkg::CSR_CW_MIN:        cfg_in.cw_min        = csr_wdata;
            csmab_pkg::CSR_CW_MAX:        cfg_in.cw_max        = csr_wdata;
            csmab_pkg::CSR_INITIAL_BE:    cfg_in.initial_be    = csr_wdata[3:0];
            csmab_pkg::CSR_MAX_BE:        cfg_in.max_be        = csr_wdata[3:0];
            csmab_pkg::CSR_PAYLOAD_SLOTS: cfg_in.payload_slots = csr_wdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.difs_slots    <= csmab_pkg::RESET_DIFS_SLOTS;
         cfg_ff.cw_min        <= csmab_pkg::RESET_CW_MIN;
         cfg_ff.cw_max        <= csmab_pkg::RESET_CW_MAX;
         cfg_ff.initial_be    <= csmab_pkg::RESET_INITIAL_BE;
         cfg_ff.max_be        <= csmab_pkg::RESET_MAX_BE;
         cfg_ff.payload_slots <= csmab_pkg::RESET_PAYLOAD_SLOTS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/core/csmab_core.sv
// Station state registers and the per-slot update of the backoff state machine.
// Depends on csmab_pkg for the phase enum, channel codes and shared structs.
`default_nettype none

module csmab_core (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire logic [1:0]    channel_state,
   input  wire logic [15:0]   random_draw,
   input  csmab_pkg::cfg_type cfg,
   output csmab_pkg::rsp_type rsp_next
);

   csmab_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  ifs_count_ff, ifs_count_in;
   logic [15:0] window_ff, window_in;
   logic [3:0]  exponent_ff, exponent_in;
   logic [15:0] slots_left_ff, slots_left_in;
   logic        collided_ff, collided_in;
   logic [15:0] collisions_ff, collisions_in;
   logic [31:0] slot_index_ff, slot_index_in;
   logic [31:0] done_slot_ff, done_slot_in;

   logic        idle;
   logic [15:0] draw_mask;
   logic [15:0] draw_raw;
   logic [15:0] draw_low;
   logic [15:0] draw_window;
   logic [15:0] window_dec;

   assign idle      = (channel_state == csmab_pkg::CH_IDLE);
   assign draw_mask = 16'((17'd1 << exponent_ff) - 17'd1);
   assign draw_raw  = random_draw & draw_mask;
   assign draw_low  = (draw_raw < cfg.cw_min) ? cfg.cw_min : draw_raw;
   assign draw_window = (draw_low > cfg.cw_max) ? cfg.cw_max : draw_low;
   assign window_dec = (idle && window_ff != 16'd0) ? window_ff - 16'd1 : window_ff;

   always_comb begin
      phase_in      = phase_ff;
      ifs_count_in  = ifs_count_ff;
      window_in     = window_ff;
      exponent_in   = exponent_ff;
      slots_left_in = slots_left_ff;
      collided_in   = collided_ff;
      collisions_in = collisions_ff;
      done_slot_in  = done_slot_ff;
      slot_index_in = slot_index_ff + 32'd1;

      if (phase_ff != csmab_pkg::PH_EXITED && channel_state == csmab_pkg::CH_DIRTY) begin
         collided_in = 1'b1;
      end

      case (phase_ff)
         csmab_pkg::PH_WAIT: begin
            if (idle) begin
               if (ifs_count_ff == cfg.difs_slots) begin
                  ifs_count_in = 8'd0;
                  phase_in     = csmab_pkg::PH_BACKOFF;
                  window_in    = draw_window;
                  if (exponent_ff < cfg.max_be) begin
                     exponent_in = exponent_ff + 4'd1;
                  end
               end else begin
                  ifs_count_in = ifs_count_ff + 8'd1;
               end
            end
         end
         csmab_pkg::PH_TX: begin
            if (slots_left_ff <= 16'd1) begin
               slots_left_in = 16'd0;
               if (collided_in) begin
                  if (collisions_ff != 16'hFFFF) begin
                     collisions_in = collisions_ff + 16'd1;
                  end
                  collided_in = 1'b0;
                  phase_in    = csmab_pkg::PH_WAIT;
               end else begin
                  phase_in = csmab_pkg::PH_COMPLETE;
               end
            end else begin
               slots_left_in = slots_left_ff - 16'd1;
            end
         end
         csmab_pkg::PH_BACKOFF: begin
            collided_in = 1'b0;
            window_in   = window_dec;
            if (window_dec == 16'd0) begin
               phase_in      = csmab_pkg::PH_TX;
               slots_left_in = cfg.payload_slots;
               ifs_count_in  = 8'd0;
            end
         end
         csmab_pkg::PH_COMPLETE: begin
            done_slot_in = slot_index_ff - 32'd1;
            exponent_in  = cfg.initial_be;
            ifs_count_in = 8'd0;
            window_in    = 16'd0;
            phase_in     = csmab_pkg::PH_EXITED;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= csmab_pkg::PH_WAIT;
         ifs_count_ff  <= 8'd0;
         window_ff     <= 16'd0;
         exponent_ff   <= csmab_pkg::RESET_INITIAL_BE;
         slots_left_ff <= csmab_pkg::RESET_PAYLOAD_SLOTS;
         collided_ff   <= 1'b0;
         collisions_ff <= 16'd0;
         slot_index_ff <= 32'd0;
         done_slot_ff  <= 32'hFFFF_FFFF;
      end else if (step) begin
         phase_ff      <= phase_in;
         ifs_count_ff  <= ifs_count_in;
         window_ff     <= window_in;
         exponent_ff   <= exponent_in;
         slots_left_ff <= slots_left_in;
         collided_ff   <= collided_in;
         collisions_ff <= collisions_in;
         slot_index_ff <= slot_index_in;
         done_slot_ff  <= done_slot_in;
      end
   end

   always_comb begin
      rsp_next.station_state    = csmab_pkg::station_code(phase_in);
      rsp_next.transmitting     = (phase_in == csmab_pkg::PH_TX);
      rsp_next.backoff_left     = window_in;
      rsp_next.backoff_exponent = exponent_in;
      rsp_next.retry_count      = collisions_in;
      rsp_next.finish_slot      = done_slot_in;
   end

   // The phase register always holds exactly one hot bit.
   assert property (@(posedge clock) disable iff (reset) $onehot(phase_ff))
      else $error("phase register is not one-hot");

   // Once exited, the station stays exited.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == csmab_pkg::PH_EXITED |=> phase_ff == csmab_pkg::PH_EXITED)
      else $error("station left the exited phase");

   // A backoff slot always clears the collision mark.
   assert property (@(posedge clock) disable iff (reset)
      (step && phase_ff == csmab_pkg::PH_BACKOFF) |=> !collided_ff)
      else $error("collision mark survived a backoff slot");

   // The finish slot is only recorded on the way to the exited phase.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff != csmab_pkg::PH_EXITED |-> done_slot_ff == 32'hFFFF_FFFF)
      else $error("finish slot recorded before completion");

   // The retry count never goes down.
   assert property (@(posedge clock) disable iff (reset)
      step |=> collisions_ff >= $past(collisions_ff))
      else $error("retry count decreased");

endmodule

`default_nettype wire

// File: rtl/core/csma_backoff_station.sv
// Top level of the CSMA/CA backoff station: input register, result register and handshakes.
// Instantiates csmab_cfg and csmab_core; depends on csmab_pkg.
//
//   Channel  Direction  Handshake              Contents
//   req_     in         req_valid / req_stall  channel state and random draw of one slot
//   rsp_     out        rsp_valid / rsp_stall  station state after that slot
//   csr_     in         csr_write_en           register index and write data
//
// A slot transfer is captured in the input register, processed by the update stage and
// registered in the result register; one slot per cycle sustained while rsp_stall is low.
// The single update stage between the input register and the result register sets that rate.
// Synchronous reset clears the station state and loads the register defaults.
// A stalled result holds; the input register fills behind it, then req_stall rises.
`default_nettype none

module csma_backoff_station (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [1:0]                          req_channel_state,
   input  wire logic [15:0]                         req_random_draw,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic [2:0]                          rsp_station_state,
   output      logic                                rsp_transmitting,
   output      logic [15:0]                         rsp_backoff_left,
   output      logic [3:0]                          rsp_backoff_exponent,
   output      logic [15:0]                         rsp_retry_count,
   output      logic [31:0]                         rsp_finish_slot,
   input  wire logic                                csr_write_en,
   input  wire logic [csmab_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [csmab_pkg::CsrDataWidth-1:0]  csr_wdata
);

   csmab_pkg::cfg_type cfg;
   csmab_pkg::rsp_type rsp_next;
   csmab_pkg::rsp_type rsp_ff;

   logic        in_valid_ff;
   logic [1:0]  in_channel_ff;
   logic [15:0] in_random_ff;
   logic        out_valid_ff;
   logic        step;
   logic        req_take;

   assign step      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step;
   assign req_take  = req_valid && !req_stall;

   csmab_cfg u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   csmab_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .channel_state (in_channel_ff),
      .random_draw   (in_random_ff),
      .cfg           (cfg),
      .rsp_next      (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_take || (in_valid_ff && !step);
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_channel_ff <= req_channel_state;
         in_random_ff  <= req_random_draw;
      end
      if (step) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_station_state    = rsp_ff.station_state;
   assign rsp_transmitting     = rsp_ff.transmitting;
   assign rsp_backoff_left     = rsp_ff.backoff_left;
   assign rsp_backoff_exponent = rsp_ff.backoff_exponent;
   assign rsp_retry_count      = rsp_ff.retry_count;
   assign rsp_finish_slot      = rsp_ff.finish_slot;

endmodule

`default_nettype wire
